@@ rtl/sbd_pkg.sv @@
// ----------------------------------------------------------------------------
// Spectral beat detector package
// Shared widths, reset values and defaults for the beat detector.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int BINS_DEFAULT = 8;

  localparam int BIN_W   = 3;
  localparam int POWER_W = 8;
  localparam int PEAK_W  = 9;
  localparam int FLOOR_W = 8;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 1;

  localparam logic [PEAK_W-1:0] PEAK_RESET = PEAK_W'(3);
  localparam logic [PEAK_W-1:0] PEAK_MAX   = PEAK_W'(318);

  typedef logic [BIN_W-1:0]   bin_t;
  typedef logic [POWER_W-1:0] power_t;
  typedef logic [PEAK_W-1:0]  peak_t;
  typedef logic [FLOOR_W-1:0] floor_t;

endpackage

@@ rtl/spectral_beat_detector_unit.sv @@
// ----------------------------------------------------------------------------
// Spectral beat detector
// Keeps per-bin floor, running peak and power history, flags beats per item.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes the input register, then the result register;
//   the per-bin read, update and write back happen as the result register loads.
// Throughput: one item per cycle when not stalled, same bin back to back included.
// Reset: rst (synchronous) clears both stages and sets every bin to floor 0,
//   peak 3 and power history 0.
module spectral_beat_detector_unit
  import sbd_pkg::*;
#(
  parameter int BINS = BINS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [2:0] bin, [10:3] power
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [8:0] peak_level, [16:9] floor_level
  output logic [OUT_USER_W-1:0] m_axis_tuser    // [0] beat
);

  localparam int IDX_W = (BINS > 1) ? $clog2(BINS) : 1;

  // per-bin state
  floor_t floor_store       [BINS];
  peak_t  peak_store        [BINS];
  power_t last_power_store  [BINS];
  power_t older_power_store [BINS];

  // input register
  logic   in_valid;
  bin_t   in_bin;
  power_t in_power;

  logic   advance;
  logic   fire;
  logic   in_range;
  logic [IDX_W-1:0] idx;

  peak_t  pk_old;
  floor_t fl_old;
  power_t last;
  power_t older;

  logic          local_max;
  logic [9:0]    thresh_sum;
  logic [10:0]   upd_sum;
  peak_t         pk_next;
  floor_t        fl_track;
  floor_t        fl_next;
  logic [9:0]    beat_ref;
  logic          beat;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign fire          = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_bin   <= s_axis_tdata[BIN_W-1:0];
      in_power <= s_axis_tdata[BIN_W+POWER_W-1:BIN_W];
    end
  end

  assign in_range = ({29'd0, in_bin} < 32'(BINS));
  assign idx      = IDX_W'(in_bin);

  assign pk_old = peak_store[idx];
  assign fl_old = floor_store[idx];
  assign last   = last_power_store[idx];
  assign older  = older_power_store[idx];

  always_comb begin
    thresh_sum = {2'b00, in_power} + {3'b000, pk_old[PEAK_W-1:2]};
    local_max  = (thresh_sum < {2'b00, last}) && (last > older);

    // move the peak toward the previous power, faster when it overshoots
    if ({1'b0, last} > pk_old) begin
      upd_sum = 11'(3 * pk_old) + {2'b00, last, 1'b0};
    end else begin
      upd_sum = 11'(3 * pk_old) + {3'b000, last};
    end
    pk_next = local_max ? upd_sum[10:2] : pk_old;

    if (in_power < fl_old) begin
      fl_track = in_power;
    end else if (fl_old != '0) begin
      fl_track = fl_old - FLOOR_W'(1);
    end else begin
      fl_track = fl_old;
    end

    beat_ref = {1'b0, fl_track, 1'b0} + {1'b0, pk_next};
    beat     = ({1'b0, in_power, 1'b0} > beat_ref);
    fl_next  = beat ? in_power : fl_track;
  end

  // write back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < BINS; k++) begin
        floor_store[k]       <= '0;
        peak_store[k]        <= PEAK_RESET;
        last_power_store[k]  <= '0;
        older_power_store[k] <= '0;
      end
    end else if (fire && in_range) begin
      floor_store[idx]       <= fl_next;
      peak_store[idx]        <= pk_next;
      older_power_store[idx] <= last;
      last_power_store[idx]  <= in_power;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (in_range) begin
        m_axis_tdata <= {7'd0, fl_next, pk_next};
        m_axis_tuser <= beat;
      end else begin
        m_axis_tdata <= '0;
        m_axis_tuser <= '0;
      end
    end
  end

endmodule

@@ rtl/sbd_checker.sv @@
// ----------------------------------------------------------------------------
// Spectral beat detector checker
// Port-level checks on the result stream of the beat detector.
// ----------------------------------------------------------------------------
module sbd_checker
  import sbd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // a new result needs an item taken ahead of it through the input register
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without an accepted item");

  // peak stays in range
  a_peak: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[PEAK_W-1:0] <= PEAK_MAX)
    else $error("peak out of range");

  // on a beat the floor equals a power that exceeds half the peak
  a_beat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      {1'b0, m_axis_tdata[PEAK_W+FLOOR_W-1:PEAK_W], 1'b0} >
      {1'b0, m_axis_tdata[PEAK_W-1:0]})
    else $error("beat with floor too low");

endmodule

bind spectral_beat_detector_unit sbd_checker u_sbd_checker (.*);

@@ verif/spectral_beat_detector_unit_test.sv @@
// ----------------------------------------------------------------------------
// Spectral beat detector testbench
// Streams bin/power items into the detector with random gaps and output
// stalls, predicts every bin's floor, peak and beat flag in a scoreboard and
// compares each result item field by field in arrival order.
// ----------------------------------------------------------------------------
module spectral_beat_detector_unit_test;
  import sbd_pkg::*;

  localparam int BINS        = BINS_DEFAULT;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT  = 150000;
  localparam int HOLD_CYCLES  = 60;

  typedef struct packed {
    logic   beat;
    peak_t  peak_level;
    floor_t floor_level;
  } outcome_t;

  class beat_scoreboard;
    floor_t   floor_lvl[BINS];
    peak_t    peak_lvl[BINS];
    power_t   last_pw[BINS];
    power_t   older_pw[BINS];
    outcome_t expected_q[$];
    int       errors;

    function new();
      for (int k = 0; k < BINS; k++) begin
        floor_lvl[k] = '0;
        peak_lvl[k]  = PEAK_RESET;
        last_pw[k]   = '0;
        older_pw[k]  = '0;
      end
      errors = 0;
    endfunction

    // Work out the result of one accepted item and advance the bin history.
    function void note_item(bin_t b, power_t p);
      int unsigned pk, fl, lp, op;
      outcome_t    o;
      o = '0;
      if (b < BINS) begin
        pk = peak_lvl[b];
        fl = floor_lvl[b];
        lp = last_pw[b];
        op = older_pw[b];
        // previous power was a local maximum: pull the peak toward it
        if (p + (pk >> 2) < lp && lp > op) begin
          if (lp > pk)
            pk = (3 * pk + 2 * lp) >> 2;
          else
            pk = (3 * pk + lp) >> 2;
        end
        if (p < fl)
          fl = p;
        else if (fl > 0)
          fl = fl - 1;
        if (2 * p > 2 * fl + pk) begin
          fl = p;
          o.beat = 1'b1;
        end
        peak_lvl[b]  = peak_t'(pk);
        floor_lvl[b] = floor_t'(fl);
        older_pw[b]  = last_pw[b];
        last_pw[b]   = p;
        o.peak_level  = peak_t'(pk);
        o.floor_level = floor_t'(fl);
      end
      expected_q.push_back(o);
    endfunction

    function void check_result(logic beat, peak_t pk, floor_t fl);
      outcome_t o;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item beat=%0d peak=%0d floor=%0d",
                 $time, beat, pk, fl);
        errors++;
        return;
      end
      o = expected_q.pop_front();
      if (beat !== o.beat) begin
        $display("%0t: beat mismatch, expected %0d actual %0d", $time, o.beat, beat);
        errors++;
      end
      if (pk !== o.peak_level) begin
        $display("%0t: peak_level mismatch, expected %0d actual %0d",
                 $time, o.peak_level, pk);
        errors++;
      end
      if (fl !== o.floor_level) begin
        $display("%0t: floor_level mismatch, expected %0d actual %0d",
                 $time, o.floor_level, fl);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [2:0] bin, [10:3] power
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [8:0] peak_level, [16:9] floor_level
  logic [OUT_USER_W-1:0] m_axis_tuser;   // [0] beat

  beat_scoreboard sb;
  int             cycles;
  bit             calm;      // no idling on either side
  bit             hold_req;  // ask the receiver for a long hold-off
  int             hold_left;
  power_t         level[8];  // per-bin envelope for the random part

  spectral_beat_detector_unit #(.BINS(BINS)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    cycles        = 0;
    sb            = new();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Note accepted inputs and check accepted results.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      sb.note_item(bin_t'(s_axis_tdata[BIN_W-1:0]),
                   power_t'(s_axis_tdata[BIN_W +: POWER_W]));
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser[0], peak_t'(m_axis_tdata[PEAK_W-1:0]),
                      floor_t'(m_axis_tdata[PEAK_W +: FLOOR_W]));
  end

  // Receiver: random stalls, a long hold-off on request, none while calm.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 13);
    end
  end

  // Offer one item and hold it until accepted; returns at the accepting edge.
  task automatic send_item(input bin_t b, input power_t p);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({p, b});
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(99) < 13)
      idle_cycles($urandom_range(1, 3));
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic power_t next_power(bin_t b);
    int unsigned pick;
    int          step;
    pick = $urandom_range(99);
    if (pick < 70) begin
      // random walk with occasional spikes so local maxima keep turning up
      step = $urandom_range(0, 80) - 40;
      if ($urandom_range(9) == 0)
        step = $urandom_range(0, 255);
      step = step + level[b];
      if (step < 0) step = 0;
      if (step > 255) step = 255;
      level[b] = power_t'(step);
      return level[b];
    end else if (pick < 90) begin
      return power_t'($urandom_range(255));
    end else begin
      return $urandom_range(1) ? 8'hFF : 8'h00;
    end
  endfunction

  initial begin
    bin_t b;
    for (int k = 0; k < 8; k++) level[k] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: floor at zero, beat from rest, local maximum above the peak,
    // local maximum below the peak, floor decay, peak driven high, bit patterns.
    send_item(3'd0, 8'd0);
    send_item(3'd0, 8'd255);
    send_item(3'd0, 8'd0);
    send_item(3'd0, 8'd100);
    send_item(3'd0, 8'd0);
    send_item(3'd7, 8'd200);
    send_item(3'd7, 8'd10);
    send_item(3'd3, 8'd50);
    send_item(3'd3, 8'd60);
    send_item(3'd3, 8'd60);
    send_item(3'd3, 8'd60);
    for (int k = 0; k < 4; k++) begin
      send_item(3'd5, 8'd255);
      send_item(3'd5, 8'd0);
    end
    send_item(3'd1, 8'd1);
    send_item(3'd2, 8'h55);
    send_item(3'd4, 8'hAA);
    send_item(3'd6, 8'd255);
    send_item(3'd6, 8'd254);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300)
        hold_req = 1'b1;
      if (n == 600) begin
        idle_cycles(1);
        wait_drained();
      end
      calm = (n >= 700 && n < 900);
      maybe_idle();
      b = bin_t'($urandom_range(7));
      send_item(b, next_power(b));
    end
    calm = 1'b0;

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
